FILE: src/ordwp_pkg.sv
package ordwp_pkg;

  localparam int WIN_REGS    = 4;
  localparam int WIN_W       = 36;
  localparam int WIN_FIELD_W = 18;
  localparam int OFF_W       = 30;
  localparam int ROFF_W      = 17;
  localparam int SLOT_W      = 2;
  localparam int QUEUE_DEPTH = 2;
  localparam int RES_W       = 32;

  localparam logic [2:0] CFG_ROMS    = 3'd0;
  localparam logic [2:0] CFG_WIN0    = 3'd1;
  localparam logic [2:0] CFG_MODE    = 3'd5;
  localparam logic [2:0] CFG_BUILTIN = 3'd6;

  localparam logic [7:0] MAP_16K      = 8'd0;
  localparam logic [7:0] MAP_OFF      = 8'd1;
  localparam logic [7:0] MAP_32K_HOLE = 8'd2;
  localparam logic [7:0] MAP_32K      = 8'd3;

  localparam logic [31:0] AREA_LO_BASE = 32'h000C_0000;
  localparam logic [31:0] AREA_LO_END  = 32'h000F_0000;
  localparam logic [31:0] AREA_HI_BASE = 32'hC000_0000;
  localparam logic [31:0] AREA_HI_END  = 32'hF000_0000;

  localparam logic [OFF_W-1:0] ADDR_CMD = OFF_W'(32'h1555);
  localparam logic [OFF_W-1:0] ADDR_KEY = OFF_W'(32'h0AAA);
  localparam logic [OFF_W-1:0] SIZE_16K = OFF_W'(32'h4000);
  localparam logic [OFF_W-1:0] SIZE_32K = OFF_W'(32'h8000);
  localparam logic [OFF_W-1:0] HOLE_LO  = OFF_W'(32'h6000);
  localparam logic [OFF_W-1:0] HOLE_HI  = OFF_W'(32'h6800);

  localparam logic [7:0] DATA_AA        = 8'hAA;
  localparam logic [7:0] DATA_55        = 8'h55;
  localparam logic [7:0] CMD_PROTECT    = 8'hA0;
  localparam logic [7:0] CMD_ARM        = 8'h80;
  localparam logic [7:0] CMD_UNPROTECT  = 8'h20;

  typedef enum logic [1:0] {
    SRC_NONE    = 2'd0,
    SRC_SLOT    = 2'd1,
    SRC_BUILTIN = 2'd2
  } src_t;

  typedef enum logic [1:0] {
    STEP_IDLE = 2'd0,
    STEP_KEY1 = 2'd1,
    STEP_KEY2 = 2'd2
  } step_t;

  typedef struct packed {
    logic [2:0]  roms_loaded;
    logic [7:0]  mapping_mode;
    logic [16:0] builtin_size;
  } cfg_t;

  typedef struct packed {
    logic              claimed;
    src_t              source;
    logic [SLOT_W-1:0] slot;
    logic [ROFF_W-1:0] rom_offset;
    logic              is_write;
    logic              at_cmd;
    logic              at_key;
    logic [7:0]        data;
  } job_t;

endpackage

FILE: src/ordwp_front.sv
module ordwp_front #(
  parameter int ACT_SLOTS = 4
) (
  input  logic                     mode,
  input  logic [31:0]              address,
  input  logic [7:0]               write_data,
  input  ordwp_pkg::cfg_t          cfg,
  input  logic [ordwp_pkg::WIN_W-1:0] windows [ACT_SLOTS],
  output ordwp_pkg::job_t          job
);
  import ordwp_pkg::*;

  logic                 in_lo;
  logic                 in_hi;
  logic [OFF_W-1:0]     off;
  logic [OFF_W-1:0]     rel;
  logic [OFF_W-1:0]     start_sel;
  logic [OFF_W-1:0]     win_start [ACT_SLOTS];
  logic [OFF_W-1:0]     win_end [ACT_SLOTS];
  logic [ACT_SLOTS-1:0] in_win;
  logic                 hit;
  logic [SLOT_W-1:0]    hit_slot;
  logic                 mapped;

  assign in_lo = (address >= AREA_LO_BASE) && (address < AREA_LO_END);
  assign in_hi = (address >= AREA_HI_BASE) && (address < AREA_HI_END);
  assign off   = in_lo ? OFF_W'(address - AREA_LO_BASE) : address[OFF_W-1:0];

  always_comb begin
    for (int i = 0; i < ACT_SLOTS; i++) begin
      win_start[i] = OFF_W'(windows[i][WIN_FIELD_W-1:0]);
      win_end[i]   = OFF_W'(windows[i][WIN_W-1:WIN_FIELD_W]);
      in_win[i]    = (int'(cfg.roms_loaded) > i) && (win_end[i] > off) &&
                     (win_start[i] <= off);
    end
    hit       = 1'b0;
    hit_slot  = '0;
    start_sel = '0;
    for (int i = ACT_SLOTS - 1; i >= 0; i--) begin
      if (in_win[i]) begin
        hit       = 1'b1;
        hit_slot  = SLOT_W'(i);
        start_sel = win_start[i];
      end
    end
  end

  assign rel = off - start_sel;

  always_comb begin
    case (cfg.mapping_mode)
      MAP_16K:      mapped = rel < SIZE_16K;
      MAP_OFF:      mapped = 1'b0;
      MAP_32K_HOLE: mapped = (rel < SIZE_32K) && !((rel >= HOLE_LO) && (rel < HOLE_HI));
      MAP_32K:      mapped = rel < SIZE_32K;
      default:      mapped = 1'b1;
    endcase
  end

  always_comb begin
    job            = '0;
    job.source     = SRC_NONE;
    job.data       = write_data;
    if (in_lo || in_hi) begin
      if (hit) begin
        if (mapped) begin
          job.claimed    = 1'b1;
          job.source     = SRC_SLOT;
          job.slot       = hit_slot;
          job.rom_offset = rel[ROFF_W-1:0];
          job.is_write   = mode;
          job.at_cmd     = rel == ADDR_CMD;
          job.at_key     = rel == ADDR_KEY;
        end
      end else if ((cfg.builtin_size != '0) && (off < OFF_W'(cfg.builtin_size))) begin
        job.claimed    = 1'b1;
        job.source     = SRC_BUILTIN;
        job.rom_offset = off[ROFF_W-1:0];
      end
    end
  end

endmodule

FILE: src/ordwp_queue.sv
module ordwp_queue (
  input  logic            clk,
  input  logic            rst,
  input  logic            push,
  input  ordwp_pkg::job_t push_job,
  output logic            not_full,
  input  logic            pop,
  output logic            not_empty,
  output ordwp_pkg::job_t pop_job
);
  import ordwp_pkg::*;

  localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

  job_t             entries [QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;

  assign not_full  = count != CNT_W'(QUEUE_DEPTH);
  assign not_empty = count != '0;
  assign pop_job   = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_job;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      case ({push, pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    !(push && !not_full && !pop))
    else $error("queue written while full");

endmodule

FILE: src/ordwp_back.sv
module ordwp_back #(
  parameter int ACT_SLOTS = 4
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         q_valid,
  input  ordwp_pkg::job_t              q_job,
  output logic                         q_pop,
  output logic                         m_valid,
  input  logic                         m_ready,
  output logic [ordwp_pkg::RES_W-1:0]  m_data
);
  import ordwp_pkg::*;

  step_t                step [ACT_SLOTS];
  step_t                step_next [ACT_SLOTS];
  logic [ACT_SLOTS-1:0] arm;
  logic [ACT_SLOTS-1:0] arm_next;
  logic [ACT_SLOTS-1:0] unl;
  logic [ACT_SLOTS-1:0] unl_next;
  logic                 commit;

  logic                 out_valid;
  logic                 out_claimed;
  src_t                 out_source;
  logic [SLOT_W-1:0]    out_slot;
  logic [ROFF_W-1:0]    out_offset;
  logic                 out_commit;
  logic [7:0]           out_data;

  assign q_pop   = q_valid && (!out_valid || m_ready);
  assign m_valid = out_valid;
  assign m_data  = {1'b0, out_data, out_commit, out_offset, out_slot, out_source, out_claimed};

  always_comb begin
    step_next = step;
    arm_next  = arm;
    unl_next  = unl;
    commit    = 1'b0;
    if (q_pop && q_job.is_write && (q_job.source == SRC_SLOT)) begin
      for (int s = 0; s < ACT_SLOTS; s++) begin
        if (SLOT_W'(s) == q_job.slot) begin
          if (q_job.at_cmd && (q_job.data == DATA_AA) && (step[s] == STEP_IDLE)) begin
            step_next[s] = STEP_KEY1;
          end else if (q_job.at_cmd && (step[s] == STEP_KEY2) &&
                       (q_job.data == CMD_PROTECT)) begin
            step_next[s] = STEP_IDLE;
            arm_next[s]  = 1'b0;
            unl_next[s]  = 1'b0;
          end else if (q_job.at_cmd && (step[s] == STEP_KEY2) &&
                       (q_job.data == CMD_ARM)) begin
            step_next[s] = STEP_IDLE;
            arm_next[s]  = 1'b1;
          end else if (q_job.at_cmd && (step[s] == STEP_KEY2) &&
                       (q_job.data == CMD_UNPROTECT)) begin
            step_next[s] = STEP_IDLE;
            arm_next[s]  = 1'b0;
            if (arm[s]) begin
              unl_next[s] = 1'b1;
            end
          end else if (q_job.at_key && (q_job.data == DATA_55) &&
                       (step[s] == STEP_KEY1)) begin
            step_next[s] = STEP_KEY2;
          end else begin
            step_next[s] = STEP_IDLE;
            arm_next[s]  = 1'b0;
            commit       = unl[s];
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int s = 0; s < ACT_SLOTS; s++) begin
        step[s] <= STEP_IDLE;
      end
      arm       <= '0;
      unl       <= '0;
      out_valid <= 1'b0;
    end else begin
      step <= step_next;
      arm  <= arm_next;
      unl  <= unl_next;
      if (q_pop) begin
        out_valid <= 1'b1;
      end else if (m_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      out_claimed <= q_job.claimed;
      out_source  <= q_job.source;
      out_slot    <= q_job.slot;
      out_offset  <= q_job.rom_offset;
      out_commit  <= commit;
      out_data    <= commit ? q_job.data : 8'h00;
    end
  end

  a_commit_slot: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_commit |-> out_claimed && (out_source == SRC_SLOT))
    else $error("commit reported without an option ROM slot hit");

  a_unclaimed_clean: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_claimed |-> (out_source == SRC_NONE) && (out_offset == '0) &&
                                  (out_data == 8'h00))
    else $error("unclaimed transaction carries data");

  a_unprotect_cause: assert property (@(posedge clk) disable iff (rst)
    (|(unl & ~$past(unl))) |-> $past(q_pop && q_job.is_write && q_job.at_cmd &&
                                     (q_job.data == CMD_UNPROTECT)))
    else $error("slot unprotected without an unprotect command");

endmodule

FILE: src/option_rom_decode_write_protect.sv
// An accepted transaction is written into the queue and then into the output register.
// Throughput: one transaction per cycle while m_axis_tready stays high.
// The front decoder feeds a two-entry queue; the back end updates the unlock state.
// Reset clears all per-slot unlock state, the queue and the output register.
// Configuration registers reset to zero, except mapping_mode, which resets to 255.
module option_rom_decode_write_protect #(
  parameter int NUM_SLOTS = 4
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [39:0] s_axis_tdata,   // address[31:0], write_data[39:32]
  input  logic        s_axis_tuser,   // mode[0]
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [31:0] m_axis_tdata,   // claimed[0], source[2:1], slot_index[4:3],
                                      // rom_offset[21:5], write_commit[22], commit_data[30:23]
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [35:0] cfg_data
);
  import ordwp_pkg::*;

  localparam int ACT_SLOTS = (NUM_SLOTS < WIN_REGS) ? NUM_SLOTS : WIN_REGS;

  cfg_t             cfg;
  logic [WIN_W-1:0] windows [ACT_SLOTS];
  job_t             front_job;
  job_t             q_job;
  logic             q_not_full;
  logic             q_not_empty;
  logic             q_pop;
  logic             push;

  assign s_axis_tready = q_not_full;
  assign push          = s_axis_tvalid && q_not_full;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.roms_loaded  <= '0;
      cfg.mapping_mode <= 8'hFF;
      cfg.builtin_size <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_ROMS:    cfg.roms_loaded  <= cfg_data[2:0];
        CFG_MODE:    cfg.mapping_mode <= cfg_data[7:0];
        CFG_BUILTIN: cfg.builtin_size <= cfg_data[16:0];
        default:     cfg <= cfg;
      endcase
    end
  end

  for (genvar i = 0; i < ACT_SLOTS; i++) begin : g_win
    always_ff @(posedge clk) begin
      if (rst) begin
        windows[i] <= '0;
      end else if (cfg_we && (cfg_index == 3'(int'(CFG_WIN0) + i))) begin
        windows[i] <= cfg_data;
      end
    end
  end

  ordwp_front #(
    .ACT_SLOTS (ACT_SLOTS)
  ) u_front (
    .mode       (s_axis_tuser),
    .address    (s_axis_tdata[31:0]),
    .write_data (s_axis_tdata[39:32]),
    .cfg        (cfg),
    .windows    (windows),
    .job        (front_job)
  );

  ordwp_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_job  (front_job),
    .not_full  (q_not_full),
    .pop       (q_pop),
    .not_empty (q_not_empty),
    .pop_job   (q_job)
  );

  ordwp_back #(
    .ACT_SLOTS (ACT_SLOTS)
  ) u_back (
    .clk     (clk),
    .rst     (rst),
    .q_valid (q_not_empty),
    .q_job   (q_job),
    .q_pop   (q_pop),
    .m_valid (m_axis_tvalid),
    .m_ready (m_axis_tready),
    .m_data  (m_axis_tdata)
  );

endmodule

FILE: bench/testbench.sv
`timescale 1ns / 100ps

module testbench;
  import ordwp_pkg::*;

  localparam int NUM_SLOTS = 4;
  localparam int PHASE_ACCESSES = 220;
  localparam logic [7:0] MAP_FULL = 8'hFF;

  typedef struct packed {
    logic        mode;
    logic [31:0] addr;
    logic [7:0]  data;
  } access_t;

  typedef struct packed {
    logic              claimed;
    src_t              source;
    logic [SLOT_W-1:0] slot;
    logic [ROFF_W-1:0] offset;
    logic              commit;
    logic [7:0]        commit_byte;
  } decode_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [39:0] s_axis_tdata = '0;   // address[31:0], write_data[39:32]
  logic        s_axis_tuser = 1'b0; // mode[0]
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [31:0] m_axis_tdata;        // claimed[0], source[2:1], slot_index[4:3],
                                    // rom_offset[21:5], write_commit[22], commit_data[30:23]
  logic        cfg_we = 1'b0;
  logic [2:0]  cfg_index = '0;
  logic [35:0] cfg_data = '0;

  option_rom_decode_write_protect #(.NUM_SLOTS(NUM_SLOTS)) uut (
    .clk(clk),
    .rst(rst),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata(s_axis_tdata),
    .s_axis_tuser(s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata),
    .cfg_we(cfg_we),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  always #2 clk = ~clk;

  // Decoder configuration and per-slot protection state as the bench sees it.
  logic [2:0]  roms_cfg = '0;
  logic [35:0] win_cfg[NUM_SLOTS] = '{default: '0};
  logic [7:0]  map_cfg = MAP_FULL;
  logic [16:0] builtin_cfg = '0;
  step_t       unlock_q[NUM_SLOTS] = '{default: STEP_IDLE};
  logic        arm_q[NUM_SLOTS] = '{default: 1'b0};
  logic        open_q[NUM_SLOTS] = '{default: 1'b0};

  logic [35:0] cfg_plan[7];

  access_t bus_accesses[$];
  decode_t predicted_decodes[$];
  access_t current;

  int  send_idle_pct = 21;
  int  recv_idle_pct = 21;
  bit  hold_send = 1'b0;
  int  queued = 0;
  int  accesses_sent = 0;
  int  decodes_checked = 0;
  int  claims_seen = 0;
  int  commits_seen = 0;
  int  mismatches = 0;
  int  settings_run = 0;

  function automatic decode_t decode_access(access_t a);
    decode_t     r;
    logic [31:0] off;
    logic [31:0] wstart;
    logic [31:0] wend;
    logic [31:0] rel;
    int          count;
    bit          in_map;
    bit          handled;
    r = '0;
    r.source = SRC_NONE;
    if (a.addr >= AREA_LO_BASE && a.addr < AREA_LO_END) begin
      off = a.addr - AREA_LO_BASE;
    end else if (a.addr >= AREA_HI_BASE && a.addr < AREA_HI_END) begin
      off = a.addr - AREA_HI_BASE;
    end else begin
      return r;
    end
    count = (roms_cfg > NUM_SLOTS) ? NUM_SLOTS : int'(roms_cfg);
    for (int i = 0; i < count; i++) begin
      wstart = 32'(win_cfg[i][17:0]);
      wend = 32'(win_cfg[i][35:18]);
      if (wend > off && wstart <= off) begin
        rel = off - wstart;
        case (map_cfg)
          MAP_16K: in_map = rel < SIZE_16K;
          MAP_OFF: in_map = 1'b0;
          MAP_32K_HOLE: in_map = rel < SIZE_32K && !(rel >= HOLE_LO && rel < HOLE_HI);
          MAP_32K: in_map = rel < SIZE_32K;
          default: in_map = 1'b1;
        endcase
        if (!in_map) return r;
        r.claimed = 1'b1;
        r.source = SRC_SLOT;
        r.slot = i[SLOT_W-1:0];
        r.offset = rel[ROFF_W-1:0];
        if (a.mode) begin
          handled = 1'b0;
          if (rel == 32'(ADDR_CMD)) begin
            if (a.data == DATA_AA && unlock_q[i] == STEP_IDLE) begin
              unlock_q[i] = STEP_KEY1;
              handled = 1'b1;
            end else if (unlock_q[i] == STEP_KEY2) begin
              if (a.data == CMD_PROTECT) begin
                open_q[i] = 1'b0;
                handled = 1'b1;
              end else if (a.data == CMD_ARM) begin
                arm_q[i] = 1'b1;
                unlock_q[i] = STEP_IDLE;
                handled = 1'b1;
              end else if (a.data == CMD_UNPROTECT) begin
                if (arm_q[i]) open_q[i] = 1'b1;
                handled = 1'b1;
              end
              if (handled && a.data != CMD_ARM) begin
                arm_q[i] = 1'b0;
                unlock_q[i] = STEP_IDLE;
              end
            end
          end else if (rel == 32'(ADDR_KEY) && a.data == DATA_55 && unlock_q[i] == STEP_KEY1) begin
            unlock_q[i] = STEP_KEY2;
            handled = 1'b1;
          end
          if (!handled) begin
            arm_q[i] = 1'b0;
            unlock_q[i] = STEP_IDLE;
            if (open_q[i]) begin
              r.commit = 1'b1;
              r.commit_byte = a.data;
            end
          end
        end
        return r;
      end
    end
    if (builtin_cfg != 0 && off < 32'(builtin_cfg)) begin
      r.claimed = 1'b1;
      r.source = SRC_BUILTIN;
      r.offset = off[ROFF_W-1:0];
    end
    return r;
  endfunction

  always @(posedge clk) begin
    if (rst) begin
      s_axis_tvalid <= 1'b0;
    end else if (!s_axis_tvalid || s_axis_tready) begin
      if (s_axis_tvalid) begin
        predicted_decodes.push_back(decode_access(current));
        accesses_sent++;
      end
      if (!hold_send && bus_accesses.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
        current = bus_accesses.pop_front();
        s_axis_tdata <= {current.data, current.addr};
        s_axis_tuser <= current.mode;
        s_axis_tvalid <= 1'b1;
      end else begin
        s_axis_tvalid <= 1'b0;
      end
    end
  end

  always @(posedge clk) begin
    m_axis_tready <= $urandom_range(99) >= recv_idle_pct;
  end

  always @(posedge clk) begin
    decode_t got;
    decode_t want;
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      got.claimed = m_axis_tdata[0];
      got.source = src_t'(m_axis_tdata[2:1]);
      got.slot = m_axis_tdata[4:3];
      got.offset = m_axis_tdata[21:5];
      got.commit = m_axis_tdata[22];
      got.commit_byte = m_axis_tdata[30:23];
      if (predicted_decodes.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("Unexpected decode result: tdata %h", m_axis_tdata);
      end else begin
        want = predicted_decodes.pop_front();
        decodes_checked++;
        if (got.claimed) claims_seen++;
        if (got.commit) commits_seen++;
        if (got.claimed !== want.claimed || got.source !== want.source ||
            got.slot !== want.slot || got.offset !== want.offset ||
            got.commit !== want.commit || got.commit_byte !== want.commit_byte) begin
          mismatches++;
          if (mismatches <= 10) begin
            $display("Decode mismatch #%0d: expected claimed %0d source %0d slot %0d offset %h",
                     decodes_checked, want.claimed, want.source, want.slot, want.offset);
            $display("  commit %0d byte %h; got claimed %0d source %0d slot %0d offset %h",
                     want.commit, want.commit_byte, got.claimed, got.source, got.slot, got.offset);
            $display("  commit %0d byte %h", got.commit, got.commit_byte);
          end
        end
      end
    end
  end

  task automatic push(input logic mode, input logic [31:0] addr, input logic [7:0] data);
    access_t a;
    a.mode = mode;
    a.addr = addr;
    a.data = data;
    bus_accesses.push_back(a);
    queued++;
  endtask

  task automatic drain();
    while (bus_accesses.size() != 0 || s_axis_tvalid || predicted_decodes.size() != 0)
      @(posedge clk);
  endtask

  task automatic program_registers();
    for (int r = 0; r < 7; r++) begin
      @(posedge clk);
      cfg_we <= 1'b1;
      cfg_index <= r[2:0];
      cfg_data <= cfg_plan[r];
    end
    @(posedge clk);
    cfg_we <= 1'b0;
    roms_cfg = cfg_plan[CFG_ROMS][2:0];
    for (int i = 0; i < NUM_SLOTS; i++) win_cfg[i] = cfg_plan[CFG_WIN0 + i];
    map_cfg = cfg_plan[CFG_MODE][7:0];
    builtin_cfg = cfg_plan[CFG_BUILTIN][16:0];
    settings_run++;
  endtask

  function automatic logic [35:0] window(input logic [17:0] wstart, input logic [17:0] wend);
    return {wend, wstart};
  endfunction

  function automatic logic [35:0] pick_window(input bit wild);
    logic [31:0] wstart;
    logic [31:0] wend;
    if (wild && $urandom_range(1)) return {4'($urandom_range(15)), 32'($urandom())};
    wstart = $urandom_range(0, 32'h2C000);
    if ($urandom_range(1)) wstart[10:0] = '0;
    case ($urandom_range(3))
      0: wend = wstart + 32'h4000;
      1: wend = wstart + 32'h8000;
      2: wend = wstart + 32'h10000;
      default: wend = wstart + $urandom_range(32'h2000, 32'h20000);
    endcase
    if (wend > 32'h3FFFF) wend = 32'h3FFFF;
    if ($urandom_range(9) == 0) wend = wstart - $urandom_range(0, 1);
    return window(wstart[17:0], wend[17:0]);
  endfunction

  function automatic logic [31:0] slot_addr(input int s, input logic [31:0] rel);
    logic [31:0] off;
    off = 32'(win_cfg[s][17:0]) + rel;
    if (off < 32'h30000 && $urandom_range(1)) return AREA_LO_BASE + off;
    return AREA_HI_BASE + off;
  endfunction

  function automatic logic [31:0] slot_rel(input int s);
    logic [31:0] wlen;
    wlen = (win_cfg[s][35:18] > win_cfg[s][17:0]) ?
           32'(win_cfg[s][35:18]) - 32'(win_cfg[s][17:0]) : 32'h9000;
    if ($urandom_range(1)) wlen = (wlen > 32'h9000) ? 32'h9000 : wlen;
    return $urandom_range(0, wlen + 32'h40);
  endfunction

  task automatic push_sequence(input int s);
    int         kind;
    logic [7:0] cmd;
    kind = $urandom_range(99);
    push(1'b1, slot_addr(s, ADDR_CMD), DATA_AA);
    if (kind < 10) begin
      push(1'b1, slot_addr(s, slot_rel(s)), 8'($urandom()));
      return;
    end
    push(1'b1, slot_addr(s, ADDR_KEY), DATA_55);
    if (kind < 45) cmd = CMD_ARM;
    else if (kind < 65) cmd = CMD_PROTECT;
    else if (kind < 80) cmd = CMD_UNPROTECT;
    else cmd = 8'($urandom());
    push(1'b1, slot_addr(s, ADDR_CMD), cmd);
    if (cmd == CMD_ARM && $urandom_range(3) != 0) begin
      push(1'b1, slot_addr(s, ADDR_CMD), DATA_AA);
      push(1'b1, slot_addr(s, ADDR_KEY), DATA_55);
      push(1'b1, slot_addr(s, ADDR_CMD), CMD_UNPROTECT);
    end
    repeat ($urandom_range(1, 3)) push($urandom_range(3) != 0, slot_addr(s, slot_rel(s)),
                                      8'($urandom()));
  endtask

  task automatic push_random_accesses(input int n);
    int target;
    int s;
    int count;
    int pick;
    target = queued + n;
    count = (roms_cfg > NUM_SLOTS) ? NUM_SLOTS : int'(roms_cfg);
    while (queued < target) begin
      s = (count > 0 && $urandom_range(4) != 0) ? $urandom_range(count - 1) : $urandom_range(3);
      pick = $urandom_range(99);
      if (pick < 55) begin
        push_sequence(s);
      end else if (pick < 75) begin
        push(1'($urandom_range(1)), slot_addr(s, slot_rel(s)), 8'($urandom()));
      end else if (pick < 90) begin
        push(1'($urandom_range(1)), ($urandom_range(1) ? AREA_LO_BASE : AREA_HI_BASE) +
             $urandom_range(0, 32'h2FFFF), 8'($urandom()));
      end else begin
        push(1'($urandom_range(1)), $urandom(), 8'($urandom()));
      end
    end
  endtask

  initial begin
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    // Two slots above a 64K fallback ROM; the low 16K of the area falls back.
    cfg_plan[CFG_ROMS] = 36'd2;
    cfg_plan[CFG_WIN0] = window(18'h04000, 18'h14000);
    cfg_plan[CFG_WIN0 + 1] = window(18'h14000, 18'h24000);
    cfg_plan[CFG_WIN0 + 2] = '0;
    cfg_plan[CFG_WIN0 + 3] = '0;
    cfg_plan[CFG_MODE] = 36'(MAP_FULL);
    cfg_plan[CFG_BUILTIN] = 36'h10000;
    program_registers();
    push(1'b0, 32'h000C_0000, 8'h00);
    push(1'b0, 32'h000B_FFFF, 8'h00);
    push(1'b0, 32'h000F_0000, 8'hFF);
    push(1'b1, 32'hFFFF_FFFF, 8'hFF);
    push(1'b0, 32'hC000_0000, 8'h00);
    push(1'b0, 32'hEFFF_FFFF, 8'h00);
    push(1'b1, 32'h000C_0010, 8'h5A);
    push(1'b0, 32'h000C_4000, 8'h00);
    push(1'b1, 32'hC001_4000 + 32'(ADDR_CMD), CMD_UNPROTECT);
    push(1'b1, 32'h000C_4000 + 32'(ADDR_CMD), DATA_AA);
    push(1'b1, 32'h000C_4000 + 32'(ADDR_KEY), DATA_55);
    push(1'b1, 32'h000C_4000 + 32'(ADDR_CMD), CMD_ARM);
    push(1'b1, 32'h000C_4000 + 32'(ADDR_CMD), DATA_AA);
    push(1'b1, 32'h000C_4000 + 32'(ADDR_KEY), DATA_55);
    push(1'b1, 32'h000C_4000 + 32'(ADDR_CMD), CMD_UNPROTECT);
    push(1'b1, 32'h000C_4100, 8'h3C);
    push(1'b1, 32'h000C_4000 + 32'(ADDR_CMD), DATA_AA);
    push(1'b1, 32'h000C_4200, 8'h12);
    push(1'b1, 32'h000C_4000 + 32'(ADDR_CMD), DATA_AA);
    push(1'b1, 32'h000C_4000 + 32'(ADDR_KEY), DATA_55);
    push(1'b1, 32'h000C_4000 + 32'(ADDR_CMD), 8'h77);
    push(1'b1, 32'h000C_4000 + 32'(ADDR_CMD), DATA_AA);
    push(1'b1, 32'h000C_4000 + 32'(ADDR_KEY), DATA_55);
    push(1'b1, 32'h000C_4000 + 32'(ADDR_CMD), CMD_PROTECT);
    push(1'b1, 32'h000C_4010, 8'hFF);
    drain();
    repeat (4) @(posedge clk);

    // The hole must hide the offset without falling back to the built-in ROM.
    cfg_plan[CFG_MODE] = 36'(MAP_32K_HOLE);
    program_registers();
    push(1'b0, 32'h000C_4000 + 32'(HOLE_LO), 8'h00);
    push(1'b1, 32'h000C_4000 + 32'(HOLE_HI) - 32'd1, 8'h81);
    push(1'b0, 32'h000C_4000 + 32'(HOLE_HI), 8'h00);
    push(1'b0, 32'h000C_4000 + 32'(SIZE_32K), 8'h00);
    drain();

    for (int p = 0; p < 8; p++) begin
      repeat (4) @(posedge clk);
      for (int i = 0; i < NUM_SLOTS; i++) cfg_plan[CFG_WIN0 + i] = pick_window(p == 7);
      cfg_plan[CFG_BUILTIN] = 36'($urandom_range(0, 32'h10000));
      send_idle_pct = 21;
      recv_idle_pct = 21;
      case (p)
        0: begin
          cfg_plan[CFG_ROMS] = 36'd4;
          cfg_plan[CFG_MODE] = 36'(MAP_FULL);
          cfg_plan[CFG_BUILTIN] = '0;
        end
        1: begin
          cfg_plan[CFG_ROMS] = 36'd7;
          cfg_plan[CFG_MODE] = 36'(MAP_16K);
          cfg_plan[CFG_BUILTIN] = 36'h10000;
        end
        2: begin
          cfg_plan[CFG_ROMS] = 36'd3;
          cfg_plan[CFG_MODE] = 36'(MAP_32K_HOLE);
        end
        3: begin
          cfg_plan[CFG_ROMS] = 36'd1;
          cfg_plan[CFG_MODE] = 36'(MAP_32K);
        end
        4: begin
          cfg_plan[CFG_ROMS] = 36'd4;
          cfg_plan[CFG_MODE] = 36'($urandom_range(4, 254));
          send_idle_pct = 0;
          recv_idle_pct = 0;
        end
        5: begin
          cfg_plan[CFG_ROMS] = 36'd2;
          cfg_plan[CFG_MODE] = 36'(MAP_OFF);
        end
        6: begin
          cfg_plan[CFG_ROMS] = 36'd0;
          cfg_plan[CFG_MODE] = 36'(MAP_FULL);
          cfg_plan[CFG_BUILTIN] = 36'h10000;
          cfg_plan[CFG_WIN0] = '0;
          cfg_plan[CFG_WIN0 + 3] = '1;
        end
        default: begin
          cfg_plan[CFG_ROMS] = 36'($urandom_range(0, 7));
          cfg_plan[CFG_MODE] = 36'($urandom_range(0, 255));
        end
      endcase
      program_registers();
      push_random_accesses(PHASE_ACCESSES);
      if (p == 2) begin
        while (accesses_sent < queued - PHASE_ACCESSES / 2) @(posedge clk);
        hold_send = 1'b1;
        while (s_axis_tvalid || predicted_decodes.size() != 0) @(posedge clk);
        hold_send = 1'b0;
      end
      drain();
    end

    repeat (10) @(posedge clk);
    $display("Ran %0d bus accesses under %0d register settings, including holes and fallback.",
             accesses_sent, settings_run);
    $display("Checked %0d decodes: %0d claimed, %0d committed writes, %0d left waiting.",
             decodes_checked, claims_seen, commits_seen, predicted_decodes.size());
    if (mismatches == 0 && predicted_decodes.size() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

  initial begin
    #2_000_000;
    $display("Timeout with %0d accesses queued and %0d decodes waiting.",
             bus_accesses.size(), predicted_decodes.size());
    $display("simulation failed");
    $finish;
  end

endmodule
